>>> design/b64e_pkg.sv
// shared types, constants and the character table of the base64 encoder
package b64e_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_TWO     = 8'h32;
    localparam logic [7:0] CH_THREE   = 8'h33;
    localparam logic [7:0] CH_B       = 8'h42;
    localparam logic [7:0] CH_D       = 8'h44;
    localparam logic [7:0] CH_F       = 8'h46;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_end;
        logic       text_end;
    } out_word_t;

    // one output symbol: a sextet or a padding mark
    typedef struct packed {
        logic       pad;
        logic [5:0] val;
    } sym_t;

    // symbols caused by one input byte
    typedef struct packed {
        sym_t [3:0] sym;
        logic [1:0] last;
        logic       fin;
    } job_t;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] w;
        logic [7:0] ch;
        w = 8'(v);
        if (v < 6'd26)
        begin
            ch = CH_UPPER_A + w;
        end
        else if (v < 6'd52)
        begin
            ch = CH_LOWER_A + w - 8'd26;
        end
        else if (v < 6'd62)
        begin
            ch = CH_ZERO + w - 8'd52;
        end
        else if (v == 6'd62)
        begin
            ch = CH_PLUS;
        end
        else
        begin
            ch = CH_SLASH;
        end
        return ch;
    endfunction

endpackage

>>> design/base64_encoder.sv
// top level of the streaming base64 encoder
//
//   channel  direction  handshake          word
//   in       input      in_valid/in_stall  in_word_t: data_byte, final_byte
//   out      output     out_valid/out_stall out_word_t: out_char, run_end, text_end
//   cfg      input      cfg_valid/cfg_ready url_escape bit
//
// the back end sends one character per cycle unless out_stall holds it or the queue is empty;
// a byte yields 1 to 4 symbols, each one character, or three (%, 2 or 3, B, F or D) if escaped
// the front end takes a byte per cycle while the job queue has room
// reset clears group position, leftover bits, queue, output valid and url_escape
// in_stall is high while the queue is full; out_stall holds the output register
module base64_encoder
    import b64e_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_data
);

    logic url_escape_reg;
    logic push;
    job_t push_job;
    logic pop;
    job_t head;
    logic full;
    logic empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            url_escape_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            url_escape_reg <= cfg_data;
        end
    end

    b64e_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .push     (push),
        .push_job (push_job),
        .full     (full)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .full     (full),
        .empty    (empty)
    );

    b64e_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .url_escape (url_escape_reg),
        .head       (head),
        .empty      (empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

>>> design/b64e_front.sv
// front end: accepts bytes, tracks group position and builds symbol jobs
module b64e_front
    import b64e_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_word_t in_data,
    output logic     push,
    output job_t     push_job,
    input  logic     full
);

    logic [1:0] pos_reg;
    logic [1:0] pos_next;
    logic [3:0] left_reg;
    logic [3:0] left_next;
    logic       accept;
    logic [7:0] b;
    logic       fin;

    assign in_stall = full;
    assign accept   = in_valid && !full;
    assign push     = accept;
    assign b        = in_data.data_byte;
    assign fin      = in_data.final_byte;

    always_comb
    begin
        push_job     = '0;
        push_job.fin = fin;
        pos_next     = pos_reg;
        left_next    = left_reg;
        case (pos_reg)
            2'd1:
            begin
                push_job.sym[0].val = {left_reg[1:0], b[7:4]};
                left_next           = b[3:0];
                pos_next            = 2'd2;
                if (fin)
                begin
                    push_job.sym[1].val = {b[3:0], 2'b00};
                    push_job.sym[2].pad = 1'b1;
                    push_job.last       = 2'd2;
                end
            end
            2'd2:
            begin
                push_job.sym[0].val = {left_reg, b[7:6]};
                push_job.sym[1].val = b[5:0];
                push_job.last       = 2'd1;
                left_next           = 4'd0;
                pos_next            = 2'd0;
            end
            default:
            begin
                push_job.sym[0].val = b[7:2];
                left_next           = {2'b00, b[1:0]};
                pos_next            = 2'd1;
                if (fin)
                begin
                    push_job.sym[1].val = {b[1:0], 4'b0000};
                    push_job.sym[2].pad = 1'b1;
                    push_job.sym[3].pad = 1'b1;
                    push_job.last       = 2'd3;
                end
            end
        endcase
        if (fin)
        begin
            pos_next  = 2'd0;
            left_next = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= 2'd0;
            left_reg <= 4'd0;
        end
        else if (accept)
        begin
            pos_reg  <= pos_next;
            left_reg <= left_next;
        end
    end

endmodule

>>> design/b64e_queue.sv
// small job queue between front and back end
module b64e_queue
    import b64e_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic full,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            count_reg <= count_next;
        end
    end

endmodule

>>> design/b64e_back.sv
// back end: walks the symbols of each job and sends one character per cycle unless stalled or empty
module b64e_back
    import b64e_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      url_escape,
    input  job_t      head,
    input  logic      empty,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_data
);

    typedef enum logic [2:0] {
        PH_CHAR = 3'b001,
        PH_HI   = 3'b010,
        PH_LO   = 3'b100
    } phase_t;

    logic [1:0] sym_idx_reg;
    phase_t     phase_reg;
    phase_t     phase_next;
    logic       valid_reg;
    out_word_t  word_reg;
    out_word_t  word_next;
    sym_t       cur;
    logic [7:0] base_ch;
    logic       esc;
    logic       sym_done;
    logic       job_done;
    logic       advance;

    assign cur     = head.sym[sym_idx_reg];
    assign base_ch = cur.pad ? CH_EQUAL : b64_char(cur.val);
    assign esc     = url_escape
                     && (base_ch == CH_PLUS || base_ch == CH_SLASH || base_ch == CH_EQUAL);
    assign sym_done = esc ? (phase_reg == PH_LO) : 1'b1;
    assign job_done = sym_done && (sym_idx_reg == head.last);
    assign advance  = !empty && (!valid_reg || !out_stall);
    assign pop      = advance && job_done;

    always_comb
    begin
        case (phase_reg)
            PH_CHAR:
            begin
                phase_next = PH_HI;
            end
            PH_HI:
            begin
                phase_next = PH_LO;
            end
            default:
            begin
                phase_next = PH_CHAR;
            end
        endcase
    end

    always_comb
    begin
        case (phase_reg)
            PH_CHAR:
            begin
                word_next.out_char = esc ? CH_PERCENT : base_ch;
            end
            PH_HI:
            begin
                word_next.out_char = (base_ch == CH_EQUAL) ? CH_THREE : CH_TWO;
            end
            PH_LO:
            begin
                if (base_ch == CH_PLUS)
                begin
                    word_next.out_char = CH_B;
                end
                else if (base_ch == CH_SLASH)
                begin
                    word_next.out_char = CH_F;
                end
                else
                begin
                    word_next.out_char = CH_D;
                end
            end
            default:
            begin
                word_next.out_char = base_ch;
            end
        endcase
        word_next.run_end  = job_done;
        word_next.text_end = job_done && head.fin;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            word_reg <= word_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_idx_reg <= 2'd0;
            phase_reg   <= PH_CHAR;
            valid_reg   <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                valid_reg <= 1'b1;
                if (sym_done)
                begin
                    phase_reg   <= PH_CHAR;
                    sym_idx_reg <= job_done ? 2'd0 : sym_idx_reg + 1'b1;
                end
                else
                begin
                    phase_reg <= phase_next;
                end
            end
            else if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = word_reg;

endmodule
